>>> design/gnia_pkg.sv
`default_nettype none
package gnia_pkg;
    localparam int GroupCapacity = 128;
    localparam int NodeWidth = 9;
    localparam int StatusWidth = 2;
    localparam logic [NodeWidth-1:0] NodeEntriesReset = 9'd384;

    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_RELEASED = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> design/gnia_if.sv
`default_nettype none
interface gnia_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] request_size;
    logic [8:0] release_index;
    modport source (output valid, req_type, request_size, release_index, input ready);
    modport sink (input valid, req_type, request_size, release_index, output ready);
endinterface

interface gnia_rsp_if;
    logic       valid;
    logic       ready;
    logic [8:0] node_index;
    logic [1:0] status;
    modport source (output valid, node_index, status, input ready);
    modport sink (input valid, node_index, status, output ready);
endinterface
`default_nettype wire

>>> design/grouped_node_index_allocator.sv
// channel   | role | payload
// req       | sink | req_type, request_size, release_index
// rsp       | src  | node_index, status
// apb       | sink | node_entries at address 0
// an allocation passes from the idle state through a level set scan over every 32-group
// word (4 words at the default capacity), then a read and a modify of the mask memory and
// the output state; a release skips the scan
// after reset and after a node_entries write a rebuild pass writes every mask
// entry, one a cycle, while no request is taken
// the result register waits on rsp ready and holds the block until taken
`default_nettype none
module grouped_node_index_allocator #(
    parameter int GROUP_CAPACITY = gnia_pkg::GroupCapacity
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gnia_req_if.sink         req,
    gnia_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import gnia_pkg::*;

    localparam int GW = (GROUP_CAPACITY > 1) ? $clog2(GROUP_CAPACITY) : 1;
    localparam int WORDS = (GROUP_CAPACITY + 31) / 32;
    localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PadG = WORDS * 32;
    localparam logic [9:0] PoolNodes = 10'(GROUP_CAPACITY * 3 > 511 ? 511 : GROUP_CAPACITY * 3);

    t_state r_state, n_state;
    logic [NodeWidth-1:0] r_entries;
    logic [2:0] r_mask_mem [GROUP_CAPACITY];
    logic [2:0] r_rd;
    logic [PadG-1:0] r_set1, r_set2, r_set3;
    logic [GW-1:0] r_ptr;
    logic [WW-1:0] r_word;
    logic [2:0] r_found;
    logic [GW-1:0] r_grp, r_fgrp [3];
    logic [1:0] r_bit;
    logic r_type;
    logic [1:0] r_size;
    logic r_inrange;
    logic [NodeWidth-1:0] r_node;
    t_status r_status;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && paddr == 2'd0;
    assign prdata = {23'd0, r_entries};

    // usable entries, full group count and remainder
    logic [9:0] ent_sat;
    logic [8:0] ent_full;
    logic [1:0] ent_rem;
    assign ent_sat = ({1'b0, r_entries} > PoolNodes) ? PoolNodes : {1'b0, r_entries};
    // divide by three through the reciprocal 171/512, exact below 512
    assign ent_full = 9'((18'(ent_sat) * 18'd171) >> 9);
    assign ent_rem = 2'(ent_sat - {1'b0, 9'(ent_full * 9'd3)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= NodeEntriesReset;
        end else if (cfg_wr) begin
            r_entries <= pwdata[NodeWidth-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (32'(r_ptr) == GROUP_CAPACITY - 1) n_state = S_IDLE;
            S_IDLE:   if (req.valid) n_state = req.req_type ? S_READ : S_SCAN;
            S_SCAN:   if (32'(r_word) == WORDS - 1) n_state = S_READ;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: n_state = S_OUT;
            S_OUT:    if (rsp.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (cfg_wr) n_state = S_CLEAR;
    end

    always_comb begin
        req.ready = (r_state == S_IDLE) && !cfg_wr;
        rsp.valid = (r_state == S_OUT);
        rsp.node_index = r_node;
        rsp.status = r_status;
    end

    // lowest set bit in one 32-group word of each level set
    logic [31:0] w1, w2, w3;
    logic [4:0] p1, p2, p3;
    logic h1, h2, h3;
    always_comb begin
        w1 = r_set1[32*r_word +: 32];
        w2 = r_set2[32*r_word +: 32];
        w3 = r_set3[32*r_word +: 32];
        p1 = '0; p2 = '0; p3 = '0;
        h1 = |w1; h2 = |w2; h3 = |w3;
        for (int i = 31; i >= 0; i--) begin
            if (w1[i]) p1 = 5'(i);
            if (w2[i]) p2 = 5'(i);
            if (w3[i]) p3 = 5'(i);
        end
    end

    // release decode
    logic [8:0] rel_grp;
    logic [1:0] rel_bit;
    assign rel_grp = 9'((18'(req.release_index) * 18'd171) >> 9);
    assign rel_bit = 2'(req.release_index - 9'(rel_grp * 2'd3));

    // modify logic
    logic [2:0] bitm, nmask;
    logic [1:0] cnt, low_bit;
    logic chosen_ok;
    logic [1:0] lvl;
    logic act;
    logic [NodeWidth-1:0] res_node;
    t_status res_status;
    always_comb begin
        bitm = 3'(1) << r_bit;
        cnt = 2'(r_rd[0]) + 2'(r_rd[1]) + 2'(r_rd[2]);
        low_bit = r_rd[0] ? 2'd0 : (r_rd[1] ? 2'd1 : 2'd2);
        nmask = r_rd;
        chosen_ok = 1'b0;
        lvl = 2'd0;
        act = 1'b0;
        res_node = '0;
        res_status = ST_BAD;
        if (!r_type) begin
            if (r_size == 2'd1) begin
                lvl = r_found[0] ? 2'd1 : (r_found[1] ? 2'd2 : 2'd3);
                chosen_ok = (r_rd != 3'd0) && (|r_found);
                priority if (r_rd[0]) nmask = r_rd & 3'b110;
                else if (r_rd[1]) nmask = r_rd & 3'b101;
                else nmask = r_rd & 3'b011;
                act = chosen_ok;
                if (chosen_ok) begin
                    res_status = ST_ALLOC;
                    res_node = 9'(10'(r_grp) * 10'd3 + 10'(low_bit));
                end else begin
                    res_status = ST_NOSPACE;
                end
            end else begin
                nmask = 3'd0;
                if (r_size == 2'd3) begin
                    act = r_found[2];
                    if (r_found[2]) begin
                        res_status = ST_ALLOC;
                        res_node = 9'(10'(r_grp) * 10'd3);
                    end else begin
                        res_status = ST_NOSPACE;
                    end
                end
            end
        end else begin
            if (r_size == 2'd1) begin
                nmask = r_rd | bitm;
                act = r_inrange && (r_rd & bitm) == 3'd0;
            end else begin
                nmask = 3'b111;
                act = (r_size == 2'd3) && r_inrange && r_rd == 3'd0;
            end
            if (act) res_status = ST_RELEASED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            r_set1 <= '0; r_set2 <= '0; r_set3 <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_ptr <= '0;
                r_set1 <= '0; r_set2 <= '0; r_set3 <= '0;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_ptr <= r_ptr + 1'b1;
                        if (32'(r_ptr) < 32'(ent_full)) begin
                            r_set3[r_ptr] <= 1'b1;
                        end else if (32'(r_ptr) == 32'(ent_full) && ent_rem == 2'd1) begin
                            r_set1[r_ptr] <= 1'b1;
                        end else if (32'(r_ptr) == 32'(ent_full) && ent_rem == 2'd2) begin
                            r_set2[r_ptr] <= 1'b1;
                        end
                    end
                    S_MODIFY: begin
                        if (!r_type && r_size == 2'd1 && act) begin
                            unique case (lvl)
                                2'd1: r_set1[r_grp] <= 1'b0;
                                2'd2: begin
                                    r_set2[r_grp] <= 1'b0; r_set1[r_grp] <= 1'b1;
                                end
                                default: begin
                                    r_set3[r_grp] <= 1'b0; r_set2[r_grp] <= 1'b1;
                                end
                            endcase
                        end else if (!r_type && r_size == 2'd3 && act) begin
                            r_set3[r_grp] <= 1'b0;
                        end else if (r_type && r_size == 2'd1 && act) begin
                            unique case (cnt)
                                2'd0: r_set1[r_grp] <= 1'b1;
                                2'd1: begin
                                    r_set1[r_grp] <= 1'b0; r_set2[r_grp] <= 1'b1;
                                end
                                default: begin
                                    r_set2[r_grp] <= 1'b0; r_set3[r_grp] <= 1'b1;
                                end
                            endcase
                        end else if (r_type && r_size == 2'd3 && act) begin
                            r_set3[r_grp] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath and payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_type <= req.req_type;
                r_size <= req.request_size;
                r_word <= '0;
                r_found <= '0;
                r_bit <= rel_bit;
                r_grp <= GW'(rel_grp);
                if (req.request_size == 2'd1)
                    r_inrange <= {1'b0, req.release_index} < ent_sat
                                 && 32'(rel_grp) < GROUP_CAPACITY;
                else
                    r_inrange <= 32'(rel_grp) < GROUP_CAPACITY
                                 && (10'(rel_grp) + 10'd1) * 10'd3 <= ent_sat;
            end
            S_SCAN: begin
                r_word <= r_word + 1'b1;
                if (h1 && !r_found[0]) begin
                    r_found[0] <= 1'b1; r_fgrp[0] <= GW'({r_word, p1});
                end
                if (h2 && !r_found[1]) begin
                    r_found[1] <= 1'b1; r_fgrp[1] <= GW'({r_word, p2});
                end
                if (h3 && !r_found[2]) begin
                    r_found[2] <= 1'b1; r_fgrp[2] <= GW'({r_word, p3});
                end
            end
            S_READ: begin
                if (!r_type) begin
                    if (r_size == 2'd1)
                        r_grp <= r_found[0] ? r_fgrp[0]
                               : (r_found[1] ? r_fgrp[1] : r_fgrp[2]);
                    else
                        r_grp <= r_fgrp[2];
                end
            end
            S_MODIFY: begin
                r_node <= res_node;
                r_status <= res_status;
            end
            default: ;
        endcase
    end

    // mask memory: one read and one write port
    logic mem_we;
    logic [GW-1:0] mem_wa, mem_ra;
    logic [2:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_grp;
        mem_wd = nmask;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_ptr;
            if (32'(r_ptr) < 32'(ent_full)) mem_wd = 3'b111;
            else if (32'(r_ptr) == 32'(ent_full)) mem_wd = 3'((4'd1 << ent_rem) - 4'd1);
            else mem_wd = 3'd0;
        end else if (r_state == S_MODIFY) begin
            mem_we = act;
        end
        mem_ra = r_grp;
        if (r_state == S_READ && !r_type)
            mem_ra = (r_size == 2'd1) ? (r_found[0] ? r_fgrp[0]
                     : (r_found[1] ? r_fgrp[1] : r_fgrp[2])) : r_fgrp[2];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mask_mem[mem_wa] <= mem_wd;
        r_rd <= r_mask_mem[mem_ra];
    end
endmodule
`default_nettype wire
